@@ src/vtg_pkg.sv @@
// Package for the version token generator.
// Holds the fixed texts, the key tables and the character coding functions.
// No dependencies.
package vtg_pkg;

    localparam int SEED_W      = 32;
    localparam int VER_LEN     = 16;
    localparam int AREA_LEN    = 20;
    localparam int FIX_KEY_LEN = 12;
    localparam int NUM_DIGITS  = 8;
    localparam int TOKEN_LEN   = 28;
    localparam int B64_CHARS   = 27;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [7:0] VER_TEXT [VER_LEN] = '{
        8'h43, 8'h48, 8'h20, 8'h56, 8'h33, 8'h2E, 8'h36, 8'h30,
        8'h2D, 8'h36, 8'h33, 8'h30, 8'h33, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] FIX_KEY [FIX_KEY_LEN] = '{
        8'h48, 8'h75, 8'h61, 8'h57, 8'h65, 8'h69,
        8'h33, 8'h43, 8'h4F, 8'h4D, 8'h31, 8'h58
    };

    typedef logic [7:0] t_byte;

    // Both passes of the fixed key folded into one byte per position.
    function automatic t_byte fix_pair(input int pos);
        return FIX_KEY[pos % FIX_KEY_LEN] ^ FIX_KEY[(AREA_LEN - 1 - pos) % FIX_KEY_LEN];
    endfunction

    function automatic t_byte hex_digit(input logic [3:0] nib);
        t_byte r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

    function automatic t_byte b64_char(input logic [5:0] idx);
        t_byte r;
        if (idx < 6'd26) begin
            r = 8'h41 + {2'd0, idx};
        end else if (idx < 6'd52) begin
            r = 8'h61 + {2'd0, idx} - 8'd26;
        end else if (idx < 6'd62) begin
            r = 8'h30 + {2'd0, idx} - 8'd52;
        end else if (idx == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

endpackage

@@ src/vtg_ifs.sv @@
// Channel interfaces of the version token generator.
// One interface for seed items and one for token items; uses vtg_pkg.
interface vtg_seed_if import vtg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEED_W-1:0] seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

interface vtg_token_if;
    logic        valid;
    logic        ready;
    logic [63:0] token_chars_0_7;
    logic [63:0] token_chars_8_15;
    logic [63:0] token_chars_16_23;
    logic [31:0] token_chars_24_27;

    modport source (output valid, output token_chars_0_7, output token_chars_8_15,
                    output token_chars_16_23, output token_chars_24_27, input ready);
    modport sink   (input valid, input token_chars_0_7, input token_chars_8_15,
                    input token_chars_16_23, input token_chars_24_27, output ready);
endinterface

@@ src/version_token_generator.sv @@
// Version token generator: seed items in, 28-character token items out.
// Depends on vtg_pkg and the channel interfaces in vtg_ifs.sv.
//
//   channel      direction  payload
//   i_seed_ch    in         seed (32 bits)
//   o_token_ch   out        token_chars_0_7, _8_15, _16_23 (64 bits), _24_27 (32 bits)
//
// Three register stages: hex digits, keyed byte area, Base64 characters.
// An item is taken every cycle unless a stalled output backs up a full pipeline.
// A stalled output holds its item while earlier stages keep filling behind it.
// Reset clears the stage valid bits only.
module version_token_generator import vtg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vtg_seed_if.sink     i_seed_ch,
    vtg_token_if.source  o_token_ch
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    t_byte             r_digits [NUM_DIGITS];
    logic [SEED_W-1:0] r_seed1;
    t_byte             r_area   [AREA_LEN];
    logic [8*TOKEN_LEN-1:0] r_tok;

    t_byte             n_digits [NUM_DIGITS];
    t_byte             n_area   [AREA_LEN];
    logic [8*TOKEN_LEN-1:0] n_tok;
    logic [6*B64_CHARS-1:0] bits;

    assign en3 = !r_v3 || o_token_ch.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_seed_ch.ready = en1;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            n_digits[i] = hex_digit(i_seed_ch.seed[SEED_W-1-4*i -: 4]);
        end
    end

    always_comb begin
        for (int i = 0; i < AREA_LEN; i++) begin
            if (i < VER_LEN) begin
                n_area[i] = VER_TEXT[i] ^ r_digits[i % NUM_DIGITS]
                          ^ r_digits[NUM_DIGITS - 1 - (i % NUM_DIGITS)] ^ fix_pair(i);
            end else begin
                n_area[i] = r_seed1[SEED_W-1-8*(i-VER_LEN) -: 8] ^ fix_pair(i);
            end
        end
    end

    always_comb begin
        bits = '0;
        for (int i = 0; i < AREA_LEN; i++) begin
            bits[6*B64_CHARS-1-8*i -: 8] = r_area[i];
        end
        n_tok = '0;
        for (int k = 0; k < B64_CHARS; k++) begin
            n_tok[8*TOKEN_LEN-1-8*k -: 8] = b64_char(bits[6*B64_CHARS-1-6*k -: 6]);
        end
        n_tok[7:0] = PAD_CHAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_seed_ch.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_seed_ch.valid) begin
            r_digits <= n_digits;
            r_seed1  <= i_seed_ch.seed;
        end
        if (en2 && r_v1) begin
            r_area <= n_area;
        end
        if (en3 && r_v2) begin
            r_tok <= n_tok;
        end
    end

    assign o_token_ch.valid             = r_v3;
    assign o_token_ch.token_chars_0_7   = r_tok[223:160];
    assign o_token_ch.token_chars_8_15  = r_tok[159:96];
    assign o_token_ch.token_chars_16_23 = r_tok[95:32];
    assign o_token_ch.token_chars_24_27 = r_tok[31:0];

endmodule

@@ src/vtg_checker.sv @@
// Port checker for the version token generator, attached by bind.
// Depends on vtg_pkg and on the top level's channel ports.
module vtg_checker import vtg_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_tail
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_pad_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_tail[7:0] == PAD_CHAR)
        else $error("Token does not end in the padding character.");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input stalled while the output stage is empty.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc ##1 i_out_ready ##1 i_out_ready) |=> i_out_valid)
        else $error("Accepted item did not reach the output in three cycles.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_tail))
        else $error("Stalled output item was dropped or changed.");

endmodule

bind version_token_generator vtg_checker u_vtg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_seed_ch.valid),
    .i_in_ready  (i_seed_ch.ready),
    .i_out_valid (o_token_ch.valid),
    .i_out_ready (o_token_ch.ready),
    .i_tail      (o_token_ch.token_chars_24_27)
);
